[src/lu_decomposition_doolittle_unit_macros.svh]
// Assertion helpers for the LU factoring unit.
`ifndef LU_DECOMPOSITION_DOOLITTLE_UNIT_MACROS_SVH
`define LU_DECOMPOSITION_DOOLITTLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define LUDL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lu unit check failed");
// Next-cycle implication
`define LUDL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lu unit check failed");
`else
`define LUDL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LUDL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/ludl_pkg.sv]
package ludl_pkg;
	localparam int FRAC_BITS = 16;
	localparam int CFG_W     = 4;
	localparam int IDX_W     = 3;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_LOAD, ST_RACC, ST_GACC, ST_RA, ST_RB, ST_MUL, ST_SUB,
		ST_FIN, ST_DIV, ST_ORD, ST_OEM
	} state_t;
endpackage

[src/ludl_ram.sv]
module ludl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[src/ludl_div.sv]
// Restoring divider: quot = sat(trunc((num << FRAC) / den)), one bit per cycle.
module ludl_div #(
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [DW-1:0] quot
);
	import ludl_pkg::*;

	localparam int NB = DW + FRAC_BITS;
	localparam int CW = $clog2(NB + 1);
	localparam logic [NB-1:0] MAG_HI = {{(FRAC_BITS + 1){1'b0}}, {(DW - 1){1'b1}}};
	localparam logic [NB-1:0] MAG_LO = {{FRAC_BITS{1'b0}}, 1'b1, {(DW - 1){1'b0}}};
	localparam logic [DW-1:0] SAT_HI = {1'b0, {(DW - 1){1'b1}}};
	localparam logic [DW-1:0] SAT_LO = {1'b1, {(DW - 1){1'b0}}};

	logic          run_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [NB-1:0] dvd_q;
	logic [DW-1:0] rem_q, den_q;
	logic [DW-1:0] num_mag, den_mag;
	logic [DW:0]   trial;
	logic          fits;

	assign num_mag = num[DW-1] ? DW'(-num) : num;
	assign den_mag = den[DW-1] ? DW'(-den) : den;
	assign trial   = {rem_q, dvd_q[NB-1]};
	assign fits    = trial >= {1'b0, den_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NB);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift/subtract datapath
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= den_mag;
			neg_q <= num[DW-1] ^ den[DW-1];
		end else if (run_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			dvd_q <= {dvd_q[NB-2:0], fits};
		end
	end

	// Sign and saturate
	always_comb begin
		if (!neg_q) begin
			quot = (dvd_q > MAG_HI) ? SAT_HI : dvd_q[DW-1:0];
		end else begin
			quot = (dvd_q > MAG_LO) ? SAT_LO : DW'(~dvd_q + 1'b1);
		end
	end

	assign done = done_q;
endmodule

[src/lu_decomposition_doolittle_unit.sv]
// Doolittle LU factoring unit, signed Q16.16, no pivoting.
// Config: write matrix_size on cfg_data with cfg_valid/cfg_ready; ready only while
//   idle (busy low) and no start is offered. A write drops any partial load.
//   0 acts as 1, above MAX_SIZE acts as MAX_SIZE.
// Input: one element per beat, row-major, taken when start is high and busy low.
//   Loading takes n*n beats.
// After the last element busy stays high while one shared multiplier/subtractor
//   and one shift-subtract divider work through the matrix in a RAM with one
//   write and one read port: each term reads its entry, subtracts its products
//   one at a time, and an L entry with a nonzero pivot is then divided by it.
// Output: n*n results row-major, one per read (ST_ORD) and emit (ST_OEM) pair,
//   each shown for one cycle with result_valid; last_of_run marks (n-1, n-1).
//   The receiver cannot stall.
// Reset: matrix_size returns to MAX_SIZE, load position, singular and valid flags
//   clear; the matrix RAM is not cleared.
module lu_decomposition_doolittle_unit #(
	parameter int MAX_SIZE   = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ludl_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [DATA_WIDTH-1:0] element_value,
	output logic                        result_valid,
	output logic [ludl_pkg::IDX_W-1:0]  row_index,
	output logic [ludl_pkg::IDX_W-1:0]  column_index,
	output logic signed [DATA_WIDTH-1:0] lower_value,
	output logic signed [DATA_WIDTH-1:0] upper_value,
	output logic                        singular_flag,
	output logic                        last_of_run
);
	import ludl_pkg::*;

	`include "lu_decomposition_doolittle_unit_macros.svh"

	localparam int DW    = DATA_WIDTH;
	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_SIZE);
	localparam int NW    = $clog2(MAX_SIZE + 1);
	localparam int PW    = 2 * DW;
	localparam logic [DW-1:0] SAT_HI  = {1'b0, {(DW - 1){1'b1}}};
	localparam logic [DW-1:0] SAT_LO  = {1'b1, {(DW - 1){1'b0}}};
	localparam logic [DW-1:0] ONE_FIX = DW'(1) << FRAC_BITS;

	state_t state_q, state_d;

	logic [NW-1:0]   n_q;
	logic [RW-1:0]   nm1;
	logic [RW-1:0]   lr_q, lc_q, i_q, j_q, k_q;
	logic            upper_q, sing_q;
	logic [DW-1:0]   acc_q, pivot_q;
	logic signed [DW-1:0] a_q;
	logic signed [PW-1:0] prod_q;

	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [DW-1:0]   ram_wdata, ram_rdata;
	logic            div_go, div_done;
	logic [DW-1:0]   div_quot;

	logic            in_acc, cfg_acc, pos_last, advance, done_all;
	logic [RW-1:0]   row_sel, col_sel;
	logic [DW-1:0]   prod_sat;
	logic [DW:0]     diff;
	logic [DW-1:0]   diff_sat;

	logic            valid_q, last_q;
	logic [RW-1:0]   orow_q, ocol_q;
	logic [DW-1:0]   lo_q, up_q;

	function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [RW-1:0] c);
		addr_of = AW'(AW'(r) * AW'(MAX_SIZE) + AW'(c));
	endfunction

	assign nm1      = RW'(n_q - 1'b1);
	assign busy     = (state_q != ST_LOAD);
	assign cfg_ready = (state_q == ST_LOAD) && !start;
	assign cfg_acc  = cfg_valid & cfg_ready;
	assign in_acc   = start & ~busy;
	assign pos_last = (lr_q == nm1) && (lc_q == nm1);
	assign row_sel  = upper_q ? i_q : j_q;
	assign col_sel  = upper_q ? j_q : i_q;
	assign done_all = upper_q && (j_q == nm1) && (i_q == nm1);

	// Product: floor shift then saturate; running difference saturates too
	always_comb begin
		if (&prod_q[PW-1:FRAC_BITS+DW-1] || ~|prod_q[PW-1:FRAC_BITS+DW-1]) begin
			prod_sat = prod_q[FRAC_BITS+DW-1:FRAC_BITS];
		end else begin
			prod_sat = prod_q[PW-1] ? SAT_LO : SAT_HI;
		end
		diff = {acc_q[DW-1], acc_q} - {prod_sat[DW-1], prod_sat};
		if (diff[DW] != diff[DW-1]) begin
			diff_sat = diff[DW] ? SAT_LO : SAT_HI;
		end else begin
			diff_sat = diff[DW-1:0];
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM/divider controls
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = addr_of(row_sel, col_sel);
		ram_wdata = acc_q;
		ram_re    = 1'b0;
		ram_raddr = addr_of(row_sel, col_sel);
		div_go    = 1'b0;
		advance   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc) begin
					ram_we    = 1'b1;
					ram_waddr = addr_of(lr_q, lc_q);
					ram_wdata = element_value;
					if (pos_last) begin
						state_d = ST_RACC;
					end
				end
			end
			ST_RACC: begin
				ram_re  = 1'b1;
				state_d = ST_GACC;
			end
			ST_GACC: begin
				state_d = (i_q != '0) ? ST_RA : ST_FIN;
			end
			ST_RA: begin
				ram_re    = 1'b1;
				ram_raddr = addr_of(row_sel, k_q);
				state_d   = ST_RB;
			end
			ST_RB: begin
				ram_re    = 1'b1;
				ram_raddr = addr_of(k_q, col_sel);
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_SUB;
			end
			ST_SUB: begin
				state_d = (RW'(k_q + 1'b1) == i_q) ? ST_FIN : ST_RA;
			end
			ST_FIN: begin
				if (upper_q) begin
					ram_we  = 1'b1;
					advance = 1'b1;
				end else if (pivot_q == '0) begin
					ram_we    = 1'b1;
					ram_wdata = '0;
					advance   = 1'b1;
				end else begin
					div_go  = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					ram_we    = 1'b1;
					ram_wdata = div_quot;
					advance   = 1'b1;
				end
			end
			ST_ORD: begin
				ram_re    = 1'b1;
				ram_raddr = addr_of(lr_q, lc_q);
				state_d   = ST_OEM;
			end
			ST_OEM: begin
				state_d = pos_last ? ST_LOAD : ST_ORD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
		if (advance) begin
			state_d = done_all ? ST_ORD : ST_RACC;
		end
	end

	// Size, counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= NW'(MAX_SIZE);
			lr_q    <= '0;
			lc_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			upper_q <= 1'b1;
			sing_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			if (cfg_acc) begin
				if (cfg_data == '0) begin
					n_q <= NW'(1);
				end else if (cfg_data > CFG_W'(MAX_SIZE)) begin
					n_q <= NW'(MAX_SIZE);
				end else begin
					n_q <= NW'(cfg_data);
				end
				lr_q <= '0;
				lc_q <= '0;
			end
			// Row-major position walk for load and for output
			if (in_acc || state_q == ST_OEM) begin
				if (lc_q == nm1) begin
					lc_q <= '0;
					lr_q <= (lr_q == nm1) ? '0 : RW'(lr_q + 1'b1);
				end else begin
					lc_q <= RW'(lc_q + 1'b1);
				end
			end
			if (in_acc && pos_last) begin
				i_q     <= '0;
				j_q     <= '0;
				upper_q <= 1'b1;
				sing_q  <= 1'b0;
			end
			if (state_q == ST_RACC) begin
				k_q <= '0;
			end
			if (state_q == ST_SUB) begin
				k_q <= RW'(k_q + 1'b1);
			end
			if (state_q == ST_FIN && upper_q && j_q == i_q && acc_q == '0) begin
				sing_q <= 1'b1;
			end
			if (advance && !done_all) begin
				if (upper_q) begin
					if (j_q != nm1) begin
						j_q <= RW'(j_q + 1'b1);
					end else begin
						upper_q <= 1'b0;
						j_q     <= RW'(i_q + 1'b1);
					end
				end else if (j_q != nm1) begin
					j_q <= RW'(j_q + 1'b1);
				end else begin
					upper_q <= 1'b1;
					i_q     <= RW'(i_q + 1'b1);
					j_q     <= RW'(i_q + 1'b1);
				end
			end
			if (state_q == ST_OEM) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Arithmetic and result registers
	always_ff @(posedge clk) begin
		if (state_q == ST_GACC) begin
			acc_q <= ram_rdata;
		end
		if (state_q == ST_SUB) begin
			acc_q <= diff_sat;
		end
		if (state_q == ST_RB) begin
			a_q <= $signed(ram_rdata);
		end
		if (state_q == ST_MUL) begin
			prod_q <= a_q * $signed(ram_rdata);
		end
		if (state_q == ST_FIN && upper_q && j_q == i_q) begin
			pivot_q <= acc_q;
		end
		if (state_q == ST_OEM) begin
			orow_q <= lr_q;
			ocol_q <= lc_q;
			last_q <= pos_last;
			if (lr_q > lc_q) begin
				lo_q <= ram_rdata;
				up_q <= '0;
			end else if (lr_q == lc_q) begin
				lo_q <= ONE_FIX;
				up_q <= ram_rdata;
			end else begin
				lo_q <= '0;
				up_q <= ram_rdata;
			end
		end
	end

	ludl_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ludl_div #(
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go),
		.num   (acc_q),
		.den   (pivot_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign result_valid  = valid_q;
	assign row_index     = IDX_W'(orow_q);
	assign column_index  = IDX_W'(ocol_q);
	assign lower_value   = lo_q;
	assign upper_value   = up_q;
	assign singular_flag = sing_q;
	assign last_of_run   = last_q;

	// Checks
	`LUDL_ASSERT_IMP(a_div_nonzero, clk, arst_n, div_go, pivot_q != '0)
	`LUDL_ASSERT_NXT(a_last_ends, clk, arst_n, result_valid && last_of_run, !result_valid)
	`LUDL_ASSERT_IMP(a_pos_range, clk, arst_n, result_valid, orow_q <= nm1 && ocol_q <= nm1)
endmodule

[test/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ludl_pkg::*;

	localparam int MAXN = 8;
	localparam int DW = 32;
	localparam int FB = ludl_pkg::FRAC_BITS;
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [DW-1:0] lower;
		logic [DW-1:0] upper;
		logic singular;
		logic last;
	} lu_entry_t;

	// a pending beat is either an element or a size write (with idle drain first)
	typedef struct {
		bit is_size;
		logic [CFG_W-1:0] size_val;
		logic [DW-1:0] elem;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic signed [DW-1:0] element_value = '0;
	logic result_valid;
	logic [IDX_W-1:0] row_index, column_index;
	logic signed [DW-1:0] lower_value, upper_value;
	logic singular_flag, last_of_run;

	lu_decomposition_doolittle_unit #(.MAX_SIZE(MAXN), .DATA_WIDTH(DW)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.start(start), .busy(busy), .element_value(element_value),
		.result_valid(result_valid), .row_index(row_index), .column_index(column_index),
		.lower_value(lower_value), .upper_value(upper_value),
		.singular_flag(singular_flag), .last_of_run(last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor state
	longint lu_mat [MAXN*MAXN];
	int fill_count = 0;
	logic [CFG_W-1:0] size_reg = 4'd8;
	lu_entry_t lu_expected [$];
	beat_t pending [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit stim_done = 1'b0;

	function automatic longint clamp_dw(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	function automatic longint q_mul(longint a, longint b);
		longint p;
		p = a * b;
		return clamp_dw(p >>> FB); // arithmetic shift floors
	endfunction

	function automatic longint q_div(longint num, longint den);
		return clamp_dw((num * (64'sd1 <<< FB)) / den);
	endfunction

	function automatic int active_size();
		if (size_reg == 0) return 1;
		if (size_reg > MAXN) return MAXN;
		return int'(size_reg);
	endfunction

	// factor in place and queue the n*n expected entries
	task automatic factor_and_expect(int n);
		longint acc;
		bit sing;
		lu_entry_t e;
		sing = 1'b0;
		for (int i = 0; i < n; i++) begin
			for (int j = i; j < n; j++) begin
				acc = lu_mat[i*MAXN+j];
				for (int k = 0; k < i; k++)
					acc = clamp_dw(acc - q_mul(lu_mat[i*MAXN+k], lu_mat[k*MAXN+j]));
				lu_mat[i*MAXN+j] = acc;
			end
			if (lu_mat[i*MAXN+i] == 0) sing = 1'b1;
			for (int j = i + 1; j < n; j++) begin
				acc = lu_mat[j*MAXN+i];
				for (int k = 0; k < i; k++)
					acc = clamp_dw(acc - q_mul(lu_mat[j*MAXN+k], lu_mat[k*MAXN+i]));
				lu_mat[j*MAXN+i] = (lu_mat[i*MAXN+i] == 0) ? 64'sd0 :
					q_div(acc, lu_mat[i*MAXN+i]);
			end
		end
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				e.row = IDX_W'(r);
				e.col = IDX_W'(c);
				e.lower = DW'((r > c) ? lu_mat[r*MAXN+c] :
					(r == c) ? (64'sd1 <<< FB) : 64'sd0);
				e.upper = DW'((r > c) ? 64'sd0 : lu_mat[r*MAXN+c]);
				e.singular = sing;
				e.last = (r == n-1) && (c == n-1);
				lu_expected.push_back(e);
			end
		end
	endtask

	task automatic take_element(logic [DW-1:0] v);
		int n;
		n = active_size();
		if (fill_count >= n*n) fill_count = 0;
		lu_mat[(fill_count / n)*MAXN + (fill_count % n)] = longint'(signed'(v));
		fill_count++;
		if (fill_count == n*n) begin
			fill_count = 0;
			factor_and_expect(n);
		end
	endtask

	// driver: start/cfg beats from the pending queue
	bit draining = 1'b0;
	int drain_wait = 0;
	always @(posedge clk) begin
		bit took, go_start, go_cfg;
		took = 1'b0;
		go_start = start;
		go_cfg = cfg_valid;
		if (arst_n) begin
			if (start && !busy) begin
				take_element(element_value);
				void'(pending.pop_front());
				idle_cycles = 0;
				took = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				size_reg = cfg_data;
				fill_count = 0;
				void'(pending.pop_front());
				idle_cycles = 0;
				took = 1'b1;
			end
			// a taken or idle channel may offer the next beat at once
			if (took || !(start || cfg_valid)) begin
				go_start = 1'b0;
				go_cfg = 1'b0;
				if (pending.size() > 0) begin
					if (pending[0].is_size) begin
						// wait for all results and a quiet spell before writing size
						if (lu_expected.size() != 0 || busy) drain_wait = 0;
						else drain_wait++;
						if (drain_wait > 40) begin
							cfg_data <= pending[0].size_val;
							go_cfg = 1'b1;
							drain_wait = 0;
						end
					end else if (no_idle || $urandom_range(99) >= 9) begin
						element_value <= pending[0].elem;
						go_start = 1'b1;
					end
				end
			end
			start <= go_start;
			cfg_valid <= go_cfg;
		end
	end

	// monitor: results cannot be stalled
	always @(posedge clk) begin
		lu_entry_t got, want;
		if (arst_n && result_valid) begin
			idle_cycles = 0;
			got = {row_index, column_index, lower_value, upper_value, singular_flag, last_of_run};
			if (lu_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = lu_expected.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch at (%0d,%0d): exp %p got %p",
						want.row, want.col, want, got);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (idle_cycles > STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic logic [DW-1:0] rand_elem(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(32'h0003_0000) - 32'h0001_8000; // near +-1.5
			2: return {$urandom_range(7) == 0 ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return 32'h0001_0000 * $urandom_range(4);
		endcase
	endfunction

	task automatic add_size(int s);
		beat_t b;
		b.is_size = 1'b1;
		b.size_val = CFG_W'(s);
		b.elem = '0;
		pending.push_back(b);
	endtask

	task automatic add_elem(logic [DW-1:0] v);
		beat_t b;
		b.is_size = 1'b0;
		b.size_val = '0;
		b.elem = v;
		pending.push_back(b);
	endtask

	task automatic add_matrix(int n, int mode);
		for (int i = 0; i < n*n; i++) add_elem(rand_elem(mode));
	endtask

	initial begin
		int n, count;
		// directed: 1x1 extremes, 2x2 identity, zero pivot, saturation, size clamps
		add_size(1);
		add_elem(32'h7FFF_FFFF);
		add_elem(32'h8000_0000);
		add_elem(32'h0000_0000);
		add_size(2);
		add_elem(32'h0001_0000); add_elem(0); add_elem(0); add_elem(32'h0001_0000);
		add_elem(0); add_elem(32'h0002_0000); add_elem(32'h0003_0000); add_elem(32'h0001_0000);
		add_elem(32'h0000_0001); add_elem(32'h7FFF_FFFF);
		add_elem(32'h8000_0000); add_elem(32'h7FFF_FFFF);
		// partial load, then dropped by size write
		add_elem(32'h1234_5678);
		add_size(0);
		add_elem(32'hFFFF_FFFF);
		add_size(15);
		add_matrix(8, 1);
		add_size(3);
		add_matrix(3, 3);
		// random matrices of random sizes, mostly small
		count = 0;
		while (count < 110) begin
			n = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 4);
			if ($urandom_range(9) == 0) begin
				add_size($urandom_range(15));
				n = 0;
			end else begin
				add_size(n);
				add_matrix(n, $urandom_range(3));
				count += n*n;
			end
		end
		add_size(8);
		add_matrix(2, 0);   // dropped partial, not completed
		for (int i = 0; i < 10; i++) @(posedge clk);
		arst_n <= 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				no_idle = 1'b1;
				repeat (3000) @(posedge clk);
				no_idle = 1'b0;
			end
		join_none
		while (pending.size() > 0) @(posedge clk);
		while (lu_expected.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && lu_expected.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
